// ===== rtl/stq_pkg.sv =====
// sorted timer queue package: command codes, widths and default parameters
// used by the controller, the datapath and the top level
package stq_pkg;
    localparam int DEF_NUM_TIMERS       = 16;
    localparam int DEF_NUM_HANDLERS     = 16;
    localparam int DEF_TICKS_PER_SECOND = 100;
    localparam int DEF_SAMPLES_PER_TICK = 10;
    localparam int MS_PER_TICK          = 10;

    localparam logic [2:0] KIND_START_TICKS = 3'd0;
    localparam logic [2:0] KIND_START_SEC   = 3'd1;
    localparam logic [2:0] KIND_START_MS    = 3'd2;
    localparam logic [2:0] KIND_STOP        = 3'd3;
    localparam logic [2:0] KIND_ADVANCE     = 3'd4;
    localparam logic [2:0] KIND_SERVICE     = 3'd5;

    typedef struct packed {
        logic load;      // latch the transaction, clear result state
        logic prep;      // form ticks and elapsed, detect an expired head
        logic walk;      // process one slot at r_idx
        logic commit;    // apply insert or removal and finish
        logic done;      // present the result
    } t_cmd;

    typedef struct packed {
        logic walk_last;
    } t_status;
endpackage

// ===== rtl/sorted_timer_queue.sv =====
// sorted timer queue top level: joins stq_ctrl and stq_dp
// depends on stq_pkg
//
// A command is taken at a rising edge where start is high and busy is low. Each
// command passes through an accepting state, a prep state, a walk over every
// list slot, a commit state and a done state. The result is on the outputs,
// marked by o_result_valid, for one cycle: the first cycle in which busy is
// low again, so the next command can be taken in that same cycle; the receiver
// cannot stall.
module sorted_timer_queue
    import stq_pkg::*;
#(
    parameter int NUM_TIMERS       = DEF_NUM_TIMERS,
    parameter int NUM_HANDLERS     = DEF_NUM_HANDLERS,
    parameter int TICKS_PER_SECOND = DEF_TICKS_PER_SECOND,
    parameter int SAMPLES_PER_TICK = DEF_SAMPLES_PER_TICK
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_kind,
    input  logic [3:0]  i_timer_index,
    input  logic [31:0] i_amount,
    input  logic [3:0]  i_handler_index,
    output logic        o_result_valid,
    output logic [15:0] o_ready_mask,
    output logic        o_expired_found,
    output logic [3:0]  o_expired_timer,
    output logic [31:0] o_next_ticks,
    output logic        o_list_active
);
    t_cmd    cmd;
    t_status status;

    stq_ctrl u_ctrl (
        .i_clk, .i_rst_n, .start, .busy,
        .i_status(status), .o_cmd(cmd)
    );

    stq_dp #(
        .NUM_TIMERS(NUM_TIMERS), .NUM_HANDLERS(NUM_HANDLERS),
        .TICKS_PER_SECOND(TICKS_PER_SECOND), .SAMPLES_PER_TICK(SAMPLES_PER_TICK)
    ) u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .o_status(status),
        .i_kind, .i_timer_index, .i_amount, .i_handler_index,
        .o_valid(o_result_valid), .o_ready_mask, .o_expired_found,
        .o_expired_timer, .o_next_ticks, .o_list_active
    );
endmodule

// ===== rtl/stq_ctrl.sv =====
// sorted timer queue controller: sequences load, prep, slot walk, commit, done
// depends on stq_pkg
module stq_ctrl
    import stq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_status i_status,
    output t_cmd    o_cmd
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_WALK = 3'd2;
    localparam logic [2:0] S_COMM = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = S_WALK;
            end
            S_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_status.walk_last) n_state = S_COMM;
            end
            S_COMM: begin
                o_cmd.commit = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                o_cmd.done = 1'b1;
                n_state    = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    assign busy = (r_state != S_IDLE);
endmodule

// ===== rtl/stq_dp.sv =====
// sorted timer queue datapath: slot list, per-timer flags and handlers,
// one slot processed per cycle under stq_ctrl commands; depends on stq_pkg
module stq_dp
    import stq_pkg::*;
#(
    parameter int NUM_TIMERS       = DEF_NUM_TIMERS,
    parameter int NUM_HANDLERS     = DEF_NUM_HANDLERS,
    parameter int TICKS_PER_SECOND = DEF_TICKS_PER_SECOND,
    parameter int SAMPLES_PER_TICK = DEF_SAMPLES_PER_TICK
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_status     o_status,
    input  logic [2:0]  i_kind,
    input  logic [3:0]  i_timer_index,
    input  logic [31:0] i_amount,
    input  logic [3:0]  i_handler_index,
    output logic        o_valid,
    output logic [15:0] o_ready_mask,
    output logic        o_expired_found,
    output logic [3:0]  o_expired_timer,
    output logic [31:0] o_next_ticks,
    output logic        o_list_active
);
    localparam int IW = $clog2(NUM_TIMERS);
    localparam int CW = $clog2(NUM_TIMERS + 1);
    localparam logic [CW-1:0] FULL = CW'(NUM_TIMERS);

    // reciprocal constants for exact division of a 32-bit value
    localparam int MS_SH  = $clog2(MS_PER_TICK);
    localparam int SPT_SH = $clog2(SAMPLES_PER_TICK);
    localparam logic [32:0] MS_RCP  =
        33'((64'd1 << (32 + MS_SH)) / 64'(MS_PER_TICK) + 64'd1);
    localparam logic [32:0] SPT_RCP =
        33'((64'd1 << (32 + SPT_SH)) / 64'(SAMPLES_PER_TICK) + 64'd1);

    logic [3:0]  r_slot_timer [NUM_TIMERS];
    logic [31:0] r_slot_ticks [NUM_TIMERS];
    logic [3:0]  r_handler    [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] r_running;
    logic [CW-1:0] r_count;
    logic [31:0] r_last;

    logic [2:0]  r_kind;
    logic [3:0]  r_tidx, r_hidx;
    logic [31:0] r_amt, r_val;
    logic        r_act;          // timer index in range; gates start and stop
    logic        r_found;        // timer already in list, or expired head (removal)
    logic [CW-1:0] r_idx, r_ins, r_rmpos;
    logic        r_ins_set;
    logic [15:0] r_mask;
    logic        r_exp;
    logic [3:0]  r_exp_t;
    logic        r_valid;

    logic is_start, t_ok;
    logic [64:0] ms_prod;
    logic [64:0] el_prod;
    logic [31:0] diff;
    logic [31:0] ms_q;
    logic [31:0] elapsed;
    logic [3:0]  cur_t;
    logic [31:0] cur_k;
    logic [IW-1:0] ia;
    logic        in_list;
    logic        pre_rm;

    assign is_start = (r_kind == KIND_START_TICKS) || (r_kind == KIND_START_SEC)
                   || (r_kind == KIND_START_MS);
    assign t_ok     = ({28'd0, i_timer_index} < 32'(NUM_TIMERS));
    assign diff     = r_amt - r_last;
    assign ms_prod  = {33'd0, r_amt} * {32'd0, MS_RCP};
    assign ms_q     = 32'(ms_prod >> (32 + MS_SH));
    assign el_prod  = {33'd0, diff} * {32'd0, SPT_RCP};
    assign elapsed  = 32'(el_prod >> (32 + SPT_SH));
    assign ia       = r_idx[IW-1:0];
    assign in_list  = (r_idx < r_count);
    assign cur_t    = r_slot_timer[ia];
    assign cur_k    = r_slot_ticks[ia];
    assign pre_rm   = r_found && (r_idx > r_rmpos);
    assign o_status.walk_last = (r_idx == FULL - CW'(1));

    logic [CW-1:0] cnt_after_rm;
    assign cnt_after_rm = r_found ? r_count - CW'(1) : r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running <= '0;
            r_count   <= '0;
            r_last    <= '0;
            r_valid   <= 1'b0;
        end else begin
            r_valid <= i_cmd.done;
            if (i_cmd.load) begin
                r_kind <= i_kind; r_tidx <= i_timer_index;
                r_amt  <= i_amount; r_hidx <= i_handler_index;
                r_act  <= t_ok;
                r_idx  <= '0; r_found <= 1'b0; r_ins_set <= 1'b0;
                r_mask <= '0; r_exp <= 1'b0; r_exp_t <= '0;
            end
            if (i_cmd.prep) begin
                case (r_kind)
                    KIND_START_SEC: r_val <= r_amt * 32'(TICKS_PER_SECOND);
                    KIND_START_MS:  r_val <= ms_q;
                    KIND_ADVANCE:   r_val <= elapsed;
                    default:        r_val <= r_amt;
                endcase
                if (r_kind == KIND_SERVICE && r_count != '0 && r_slot_ticks[0] == '0) begin
                    r_exp   <= 1'b1;
                    r_exp_t <= r_slot_timer[0];
                    r_found <= 1'b1;
                    r_rmpos <= '0;
                    r_running[r_slot_timer[0][IW-1:0]] <= 1'b0;
                end
            end
            if (i_cmd.walk) begin
                r_idx <= r_idx + CW'(1);
                if (in_list) begin
                    if (r_kind == KIND_ADVANCE && r_val != '0) begin
                        if (r_val < cur_k) r_slot_ticks[ia] <= cur_k - r_val;
                        else begin
                            r_slot_ticks[ia] <= '0;
                            if ({28'd0, r_handler[cur_t[IW-1:0]]} < 32'(NUM_HANDLERS))
                                r_mask[r_handler[cur_t[IW-1:0]]] <= 1'b1;
                        end
                    end
                    if ((is_start || r_kind == KIND_STOP) && r_act
                        && r_running[r_tidx[IW-1:0]] && cur_t == r_tidx && !r_found) begin
                        r_found <= 1'b1;
                        r_rmpos <= r_idx;
                    end
                    if (is_start && r_act && !r_ins_set && !(cur_t == r_tidx)
                        && r_val < cur_k) begin
                        r_ins_set <= 1'b1;
                        r_ins     <= pre_rm ? r_idx - CW'(1) : r_idx;
                    end
                end
            end
            if (i_cmd.commit) begin
                if (r_kind == KIND_ADVANCE && r_val != '0) r_last <= r_amt;
                if (is_start && r_act) begin
                    if (cnt_after_rm < FULL) begin
                        for (int j = 0; j < NUM_TIMERS; j++) begin
                            logic [CW-1:0] pos, src, shf;
                            logic [CW-1:0] ins;
                            ins = r_ins_set ? r_ins : cnt_after_rm;
                            pos = CW'(j);
                            src = (r_found && pos >= r_rmpos) ? pos + CW'(1) : pos;
                            shf = (r_found && pos - CW'(1) >= r_rmpos) ? pos : pos - CW'(1);
                            if (pos == ins) begin
                                r_slot_timer[j] <= r_tidx;
                                r_slot_ticks[j] <= r_val;
                            end else if (pos > ins) begin
                                r_slot_timer[j] <= r_slot_timer[IW'(shf)];
                                r_slot_ticks[j] <= r_slot_ticks[IW'(shf)];
                            end else if (src < CW'(NUM_TIMERS)) begin
                                r_slot_timer[j] <= r_slot_timer[IW'(src)];
                                r_slot_ticks[j] <= r_slot_ticks[IW'(src)];
                            end
                        end
                        r_count <= cnt_after_rm + CW'(1);
                        r_running[r_tidx[IW-1:0]] <= 1'b1;
                        r_handler[r_tidx[IW-1:0]] <= r_hidx;
                    end else begin
                        r_count <= cnt_after_rm;
                        if (r_found) r_running[r_tidx[IW-1:0]] <= 1'b0;
                    end
                end else if (r_found) begin
                    for (int j = 0; j < NUM_TIMERS - 1; j++) begin
                        if (CW'(j) >= r_rmpos) begin
                            r_slot_timer[j] <= r_slot_timer[j+1];
                            r_slot_ticks[j] <= r_slot_ticks[j+1];
                        end
                    end
                    r_count <= r_count - CW'(1);
                    if (r_kind == KIND_STOP) r_running[r_tidx[IW-1:0]] <= 1'b0;
                end
            end
        end
    end

    assign o_valid         = r_valid;
    assign o_ready_mask    = r_mask;
    assign o_expired_found = r_exp;
    assign o_expired_timer = r_exp_t;
    assign o_list_active   = (r_count != '0);
    assign o_next_ticks    = (r_count != '0) ? r_slot_ticks[0] : '0;
endmodule
